/* rtl/mpcs_pkg.sv */
// Shared types, codes and helpers of the multi-policy CPU scheduler.
// No dependencies; used by the interfaces, the ready cell and the top level.
`timescale 1ns / 1ps
`default_nettype none

package mpcs_pkg;

   localparam int TIME_W          = 16;
   localparam int READY_DEPTH_DEF = 16;
   localparam int CPU_MAX_DEF     = 16;
   localparam int PROD_W          = TIME_W + 8;
   localparam int KEY_W           = TIME_W + 10;

   localparam logic signed [16:0] SLICE_NONE = 17'h1FFFF;

   // configuration register indexes
   localparam logic [1:0] CSR_POLICY = 2'd0;
   localparam logic [1:0] CSR_WEIGHT = 2'd1;
   localparam logic [1:0] CSR_SLICE  = 2'd2;
   localparam logic [1:0] CSR_CPUS   = 2'd3;

   typedef enum logic [1:0] {
      POL_FCFS  = 2'd0,
      POL_RR    = 2'd1,
      POL_AGING = 2'd2,
      POL_SRTF  = 2'd3
   } policy_type;

   typedef enum logic [2:0] {
      MODE_WAKE    = 3'd0,
      MODE_PREEMPT = 3'd1,
      MODE_YIELD   = 3'd2,
      MODE_TERM    = 3'd3,
      MODE_IDLE    = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      KIND_DISPATCH = 2'd0,
      KIND_PREEMPT  = 2'd1,
      KIND_NONE     = 2'd2,
      KIND_OVERFLOW = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0]        id;
      logic [7:0]        prio;
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] remaining;
      logic [TIME_W-1:0] enq;
   } entry_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

   // ordering key of an entry; lower is better, prod is waited * weight
   function automatic logic signed [KEY_W-1:0] key_value(input policy_type pol,
                                                         input entry_type e,
                                                         input logic [PROD_W-1:0] prod);
      logic signed [KEY_W-1:0] k;
      case (pol)
         POL_AGING: k = $signed({{(KEY_W-8){1'b0}}, e.prio})
                        - $signed({{(KEY_W-PROD_W){1'b0}}, prod});
         POL_SRTF:  k = $signed({{(KEY_W-TIME_W){1'b0}}, e.remaining});
         default:   k = $signed({{(KEY_W-TIME_W){1'b0}}, e.arrival});
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

/* rtl/mpcs_if.sv */
// Request and response channel interfaces of the scheduler.
// Depends on mpcs_pkg for the time width.
`timescale 1ns / 1ps
`default_nettype none

interface mpcs_req_if;
   import mpcs_pkg::*;
   logic              valid;
   logic              ready;
   logic [2:0]        mode;
   logic [3:0]        cpu_index;
   logic [7:0]        task_id;
   logic [7:0]        prio_level;
   logic [TIME_W-1:0] arrival_stamp;
   logic [TIME_W-1:0] remaining_time;
   logic [TIME_W-1:0] now_stamp;

   modport source (output valid, mode, cpu_index, task_id, prio_level,
                   arrival_stamp, remaining_time, now_stamp, input ready);
   modport sink   (input valid, mode, cpu_index, task_id, prio_level,
                   arrival_stamp, remaining_time, now_stamp, output ready);
endinterface

interface mpcs_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         result_kind;
   logic [3:0]         cpu_out;
   logic               task_present;
   logic [7:0]         task_out;
   logic signed [16:0] slice_out;

   modport source (output valid, result_kind, cpu_out, task_present, task_out,
                   slice_out, input ready);
   modport sink   (input valid, result_kind, cpu_out, task_present, task_out,
                   slice_out, output ready);
endinterface

`default_nettype wire

/* rtl/mpcs_ready_cell.sv */
// One slot of the ready queue: holds an entry, loads a new one or takes
// its right neighbor's entry when the queue closes a gap. Uses mpcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpcs_ready_cell
   import mpcs_pkg::*;
(
   input  wire logic         clock,
   input  wire cell_ctl_type ctl,
   input  wire entry_type    new_entry,
   input  wire entry_type    next_entry,
   output entry_type         entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // shift beats load; both never come together
   always_comb begin
      if (ctl.shift) begin
         entry_in = next_entry;
      end else if (ctl.load) begin
         entry_in = new_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

/* rtl/multi_policy_cpu_scheduler_core.sv */
// Multi-policy CPU scheduler: ready queue as a row of cells plus running table.
// A wake is decided at once, or after a scan of the active CPUs under aging/SRTF;
// dispatching events scan the ready cells (only the head under RR), none on an empty queue.
// One item at a time: next accept in the cycle after the result registers;
// a stalled result holds the input.
// Synchronous active-high reset empties the queue, idles CPUs, loads defaults.
`timescale 1ns / 1ps
`default_nettype none

module multi_policy_cpu_scheduler_core
   import mpcs_pkg::*;
#(
   parameter int READY_DEPTH = READY_DEPTH_DEF,
   parameter int CPU_MAX     = CPU_MAX_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   mpcs_req_if.sink         req_chan,
   mpcs_rsp_if.source       rsp_chan,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [16:0] csr_wdata
);

   localparam int RW     = $clog2(READY_DEPTH);
   localparam int CNT_W  = RW + 1;
   localparam int CW     = (CPU_MAX > 1) ? $clog2(CPU_MAX) : 1;
   localparam int NCNT_W = $clog2(CPU_MAX + 1);
   localparam int NW     = (NCNT_W > 5) ? NCNT_W : 5;

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_DISP, S_DKEY, S_DCMP, S_DMOVE, S_WKEY, S_WCMP
   } state_type;

   state_type               state_ff;
   logic                    out_pend_ff;
   policy_type              policy_ff;
   logic [7:0]              weight_ff;
   logic signed [16:0]      slice_ff;
   logic [4:0]              cpus_ff;
   logic [CNT_W-1:0]        count_ff;
   logic [CPU_MAX-1:0]      run_valid_ff;
   entry_type               run_mem [CPU_MAX];
   logic [2:0]              mode_ff;
   logic [3:0]              cpu_ff;
   entry_type               new_ff;
   logic [TIME_W-1:0]       now_ff;
   logic [RW-1:0]           rscan_ff;
   logic [CW-1:0]           cscan_ff;
   entry_type               cand_ff;
   logic [PROD_W-1:0]       prod_ff;
   entry_type               best_ff;
   logic signed [KEY_W-1:0] best_key_ff;
   logic [RW-1:0]           pick_ff;
   logic signed [KEY_W-1:0] worst_ff;
   logic [CW-1:0]           victim_ff;
   // pending result and output register
   kind_type                res_kind_ff;
   logic [3:0]              res_cpu_ff;
   logic                    res_present_ff;
   logic [7:0]              res_task_ff;
   logic signed [16:0]      res_slice_ff;
   logic                    rsp_valid_ff;
   logic [1:0]              rsp_kind_ff;
   logic [3:0]              rsp_cpu_ff;
   logic                    rsp_present_ff;
   logic [7:0]              rsp_task_ff;
   logic signed [16:0]      rsp_slice_ff;

   entry_type               cell_out [READY_DEPTH];
   cell_ctl_type            cell_ctl [READY_DEPTH];
   logic                    load_en;
   logic                    shift_en;
   entry_type               app_entry;
   logic [CW-1:0]           cpu_idx;
   logic [CW-1:0]           rd_addr;
   entry_type               run_rd;
   entry_type               cand_in;
   logic [TIME_W-1:0]       waited;
   logic [PROD_W-1:0]       prod_in;
   logic signed [KEY_W-1:0] cand_key;
   logic signed [KEY_W-1:0] worst_next;
   logic signed [KEY_W-1:0] new_key;
   logic [NW-1:0]           n_eff;
   logic                    cpu_ok;
   logic                    q_full;
   logic [RW-1:0]           last_idx;
   logic                    req_fire;
   logic                    rsp_fire;

   // active CPU count limited to the table size
   always_comb begin
      n_eff = (NW'(cpus_ff) > NW'(CPU_MAX)) ? NW'(CPU_MAX) : NW'(cpus_ff);
   end

   assign cpu_idx  = CW'(cpu_ff);
   assign cpu_ok   = NW'(cpu_ff) < n_eff;
   assign q_full   = count_ff >= CNT_W'(READY_DEPTH);
   assign last_idx = (policy_ff == POL_RR) ? '0 : RW'(count_ff - CNT_W'(1));
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_valid_ff && rsp_chan.ready;

   // running table read port: scan index during the worst-CPU scan
   assign rd_addr = (state_ff == S_WKEY) ? cscan_ff : cpu_idx;
   assign run_rd  = run_mem[rd_addr];

   // entry appended to the queue: woken task, or preempted task put back
   always_comb begin
      app_entry = new_ff;
      if (mode_ff == MODE_PREEMPT) begin
         app_entry           = run_rd;
         app_entry.remaining = new_ff.remaining;
         app_entry.enq       = now_ff;
      end
   end

   // key path: waited time times weight registered, then key and compare
   assign cand_in  = (state_ff == S_WKEY) ? run_rd : cell_out[rscan_ff];
   assign waited   = now_ff - cand_in.enq;
   assign prod_in  = PROD_W'(waited) * PROD_W'(weight_ff);
   assign cand_key = key_value(policy_ff, cand_ff, prod_ff);
   assign worst_next = (worst_ff < cand_key) ? cand_key : worst_ff;
   assign new_key  = (policy_ff == POL_SRTF)
                     ? $signed({{(KEY_W-TIME_W){1'b0}}, new_ff.remaining})
                     : $signed({{(KEY_W-8){1'b0}}, new_ff.prio});

   assign load_en  = (state_ff == S_EXEC) && !out_pend_ff && !q_full &&
                     ((mode_ff == MODE_WAKE) ||
                      (mode_ff == MODE_PREEMPT && cpu_ok && run_valid_ff[cpu_idx]));
   assign shift_en = (state_ff == S_DMOVE);

   // row of ready cells
   for (genvar i = 0; i < READY_DEPTH; i++) begin : g_cell
      assign cell_ctl[i].load  = load_en && (count_ff == CNT_W'(i));
      assign cell_ctl[i].shift = shift_en && (CNT_W'(i) >= CNT_W'(pick_ff));
      mpcs_ready_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[i]),
         .new_entry  (app_entry),
         .next_entry ((i < READY_DEPTH - 1) ? cell_out[(i + 1) % READY_DEPTH]
                                            : cell_out[i]),
         .entry      (cell_out[i])
      );
   end

   // running task table
   always_ff @(posedge clock) begin
      if (state_ff == S_DMOVE) begin
         run_mem[cpu_idx] <= best_ff;
      end
   end

   // control sequencer, configuration and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         policy_ff    <= POL_FCFS;
         weight_ff    <= '0;
         slice_ff     <= SLICE_NONE;
         cpus_ff      <= 5'd1;
         count_ff     <= '0;
         run_valid_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_POLICY: policy_ff <= policy_type'(csr_wdata[1:0]);
               CSR_WEIGHT: weight_ff <= csr_wdata[7:0];
               CSR_SLICE:  slice_ff  <= $signed(csr_wdata);
               CSR_CPUS:   cpus_ff   <= csr_wdata[4:0];
               default:    ;
            endcase
         end

         // output register; a waiting result holds the sequencer
         if (out_pend_ff && (!rsp_valid_ff || rsp_chan.ready)) begin
            rsp_valid_ff   <= 1'b1;
            rsp_kind_ff    <= res_kind_ff;
            rsp_cpu_ff     <= res_cpu_ff;
            rsp_present_ff <= res_present_ff;
            rsp_task_ff    <= res_task_ff;
            rsp_slice_ff   <= res_slice_ff;
            out_pend_ff    <= 1'b0;
            state_ff       <= S_IDLE;
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end

         if (load_en) begin
            count_ff <= count_ff + CNT_W'(1);
         end

         if (!out_pend_ff) begin
            case (state_ff)
               S_IDLE: begin
                  if (req_fire) begin
                     mode_ff           <= req_chan.mode;
                     cpu_ff            <= req_chan.cpu_index;
                     new_ff.id         <= req_chan.task_id;
                     new_ff.prio       <= req_chan.prio_level;
                     new_ff.arrival    <= req_chan.arrival_stamp;
                     new_ff.remaining  <= req_chan.remaining_time;
                     new_ff.enq        <= req_chan.now_stamp;
                     now_ff            <= req_chan.now_stamp;
                     res_kind_ff       <= KIND_NONE;
                     res_cpu_ff        <= '0;
                     res_present_ff    <= 1'b0;
                     res_task_ff       <= '0;
                     res_slice_ff      <= '0;
                     state_ff          <= S_EXEC;
                  end
               end
               S_EXEC: begin
                  case (mode_ff)
                     MODE_WAKE: begin
                        if (q_full) begin
                           res_kind_ff <= KIND_OVERFLOW;
                           out_pend_ff <= 1'b1;
                        end else if ((policy_ff == POL_AGING || policy_ff == POL_SRTF)
                                     && n_eff != '0) begin
                           cscan_ff  <= '0;
                           worst_ff  <= '0;
                           victim_ff <= '0;
                           state_ff  <= S_WKEY;
                        end else begin
                           out_pend_ff <= 1'b1;
                        end
                     end
                     MODE_PREEMPT: begin
                        if (!cpu_ok) begin
                           out_pend_ff <= 1'b1;
                        end else begin
                           run_valid_ff[cpu_idx] <= 1'b0;
                           if (run_valid_ff[cpu_idx] && q_full) begin
                              res_kind_ff <= KIND_OVERFLOW;
                              res_cpu_ff  <= cpu_ff;
                              out_pend_ff <= 1'b1;
                           end else begin
                              state_ff <= S_DISP;
                           end
                        end
                     end
                     MODE_YIELD, MODE_TERM: begin
                        if (!cpu_ok) begin
                           out_pend_ff <= 1'b1;
                        end else begin
                           run_valid_ff[cpu_idx] <= 1'b0;
                           state_ff              <= S_DISP;
                        end
                     end
                     MODE_IDLE: begin
                        if (!cpu_ok || run_valid_ff[cpu_idx] || count_ff == '0) begin
                           out_pend_ff <= 1'b1;
                        end else begin
                           state_ff <= S_DISP;
                        end
                     end
                     default: begin
                        out_pend_ff <= 1'b1;
                     end
                  endcase
               end
               S_DISP: begin
                  if (count_ff == '0) begin
                     run_valid_ff[cpu_idx] <= 1'b0;
                     res_kind_ff           <= KIND_DISPATCH;
                     res_cpu_ff            <= cpu_ff;
                     res_slice_ff          <= slice_ff;
                     out_pend_ff           <= 1'b1;
                  end else begin
                     rscan_ff <= '0;
                     state_ff <= S_DKEY;
                  end
               end
               S_DKEY: begin
                  cand_ff  <= cand_in;
                  prod_ff  <= prod_in;
                  state_ff <= S_DCMP;
               end
               S_DCMP: begin
                  if (rscan_ff == '0 || (policy_ff != POL_RR && cand_key < best_key_ff)) begin
                     best_ff     <= cand_ff;
                     best_key_ff <= cand_key;
                     pick_ff     <= rscan_ff;
                  end
                  if (rscan_ff == last_idx) begin
                     state_ff <= S_DMOVE;
                  end else begin
                     rscan_ff <= rscan_ff + RW'(1);
                     state_ff <= S_DKEY;
                  end
               end
               S_DMOVE: begin
                  run_valid_ff[cpu_idx] <= 1'b1;
                  count_ff              <= count_ff - CNT_W'(1);
                  res_kind_ff           <= KIND_DISPATCH;
                  res_cpu_ff            <= cpu_ff;
                  res_present_ff        <= 1'b1;
                  res_task_ff           <= best_ff.id;
                  res_slice_ff          <= slice_ff;
                  out_pend_ff           <= 1'b1;
                  state_ff              <= S_IDLE;
               end
               S_WKEY: begin
                  if (!run_valid_ff[cscan_ff]) begin
                     out_pend_ff <= 1'b1;
                  end else begin
                     cand_ff  <= cand_in;
                     prod_ff  <= prod_in;
                     state_ff <= S_WCMP;
                  end
               end
               S_WCMP: begin
                  worst_ff <= worst_next;
                  if (worst_ff < cand_key) begin
                     victim_ff <= cscan_ff;
                  end
                  if (NW'(cscan_ff) == n_eff - NW'(1)) begin
                     if (worst_next > 0 && new_key < worst_next) begin
                        res_kind_ff <= KIND_PREEMPT;
                        res_cpu_ff  <= 4'((worst_ff < cand_key) ? cscan_ff : victim_ff);
                     end
                     out_pend_ff <= 1'b1;
                  end else begin
                     cscan_ff <= cscan_ff + CW'(1);
                     state_ff <= S_WKEY;
                  end
               end
               default: state_ff <= S_IDLE;
            endcase
         end
      end
   end

   assign req_chan.ready        = (state_ff == S_IDLE) && !out_pend_ff;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_kind  = rsp_kind_ff;
   assign rsp_chan.cpu_out      = rsp_cpu_ff;
   assign rsp_chan.task_present = rsp_present_ff;
   assign rsp_chan.task_out     = rsp_task_ff;
   assign rsp_chan.slice_out    = rsp_slice_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(READY_DEPTH))
      else $error("ready count above depth");

   a_dispatch_pops: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DMOVE) |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("dispatch did not pop the queue");

   a_dispatch_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DMOVE) |=> run_valid_ff[$past(cpu_idx)])
      else $error("dispatched CPU not marked busy");

   a_preempt_no_task: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_PREEMPT) |-> !rsp_present_ff)
      else $error("preempt request carries a task");
`endif

endmodule

`default_nettype wire

/* test/tb_multi_policy_cpu_scheduler_core.sv */
// Self-checking testbench of the multi-policy CPU scheduler core.
// Depends on rtl/mpcs_pkg.sv, rtl/mpcs_if.sv and the core; a scoreboard class predicts each result.
`timescale 1ns / 1ps

module tb_multi_policy_cpu_scheduler_core;
   import mpcs_pkg::*;

   localparam int IDLE_LIMIT = 3000;
   localparam int PHASES     = 20;
   localparam int PHASE_LEN  = 97;

   typedef struct {
      logic [2:0]  mode;
      logic [3:0]  cpu;
      logic [7:0]  tid;
      logic [7:0]  prio;
      logic [15:0] arrival;
      logic [15:0] remaining;
      logic [15:0] now;
   } sched_event_type;

   typedef struct {
      kind_type    kind;
      logic [3:0]  cpu;
      logic        present;
      logic [7:0]  tid;
      logic [16:0] slice;
   } sched_result_type;

   // scheduler state mirror plus queue of pending expected results
   class sched_scoreboard;
      entry_type        ready_tab[16];
      int unsigned      ready_cnt;
      entry_type        run_tab[16];
      bit               run_busy[16];
      policy_type       pol;
      bit [7:0]         weight;
      bit [16:0]        slice;
      bit [4:0]         cpus;
      sched_result_type expected_q[$];
      int               errors;
      int               n_dispatch, n_preempt, n_overflow, n_none;

      function void clear();
         ready_cnt = 0;
         foreach (run_busy[i]) run_busy[i] = 0;
         pol = POL_FCFS;
         weight = 0;
         slice = SLICE_NONE;
         cpus = 1;
         errors = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [16:0] d);
         case (idx)
            CSR_POLICY: pol = policy_type'(d[1:0]);
            CSR_WEIGHT: weight = d[7:0];
            CSR_SLICE:  slice = d;
            CSR_CPUS:   cpus = d[4:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function longint aged(entry_type e, logic [15:0] now);
         logic [15:0] waited;
         waited = now - e.enq;
         return longint'(e.prio) - longint'(waited) * longint'(weight);
      endfunction

      function bit better(entry_type a, entry_type b, logic [15:0] now);
         case (pol)
            POL_FCFS:  return a.arrival < b.arrival;
            POL_AGING: return aged(a, now) < aged(b, now);
            POL_SRTF:  return a.remaining < b.remaining;
            default:   return 0;
         endcase
      endfunction

      function sched_result_type make(kind_type k, logic [3:0] c, logic p, logic [7:0] t,
                                      logic [16:0] s);
         sched_result_type r;
         r.kind = k; r.cpu = c; r.present = p; r.tid = t; r.slice = s;
         return r;
      endfunction

      // hand the strictly best ready entry to a CPU, or idle it
      function sched_result_type dispatch(int cpu, logic [15:0] now);
         int pick;
         pick = 0;
         if (ready_cnt == 0) begin
            run_busy[cpu] = 0;
            return make(KIND_DISPATCH, 4'(cpu), 1'b0, 8'd0, slice);
         end
         for (int i = 1; i < ready_cnt; i++)
            if (better(ready_tab[i], ready_tab[pick], now)) pick = i;
         run_tab[cpu] = ready_tab[pick];
         run_busy[cpu] = 1;
         for (int i = pick; i + 1 < ready_cnt; i++) ready_tab[i] = ready_tab[i + 1];
         ready_cnt--;
         return make(KIND_DISPATCH, 4'(cpu), 1'b1, run_tab[cpu].id, slice);
      endfunction

      function sched_result_type predict(sched_event_type ev);
         int          n;
         int          victim;
         bit          found;
         longint      worst;
         longint      v;
         entry_type   e;
         n = (cpus > 16) ? 16 : cpus;
         victim = 0;
         found = 0;
         worst = 0;
         if (ev.mode == MODE_WAKE) begin
            if (ready_cnt >= 16) return make(KIND_OVERFLOW, 4'd0, 1'b0, 8'd0, 17'd0);
            e.id = ev.tid; e.prio = ev.prio; e.arrival = ev.arrival;
            e.remaining = ev.remaining; e.enq = ev.now;
            ready_tab[ready_cnt] = e;
            ready_cnt++;
            // preemption check only when every active CPU is busy
            if (pol == POL_SRTF || pol == POL_AGING) begin
               for (int i = 0; i < n; i++) begin
                  if (!run_busy[i]) return make(KIND_NONE, 4'd0, 1'b0, 8'd0, 17'd0);
                  v = (pol == POL_SRTF) ? longint'(run_tab[i].remaining)
                                        : aged(run_tab[i], ev.now);
                  if (worst < v) begin
                     worst = v;
                     victim = i;
                  end
               end
               v = (pol == POL_SRTF) ? longint'(e.remaining) : aged(e, ev.now);
               found = worst > 0 && v < worst;
            end
            if (found) return make(KIND_PREEMPT, 4'(victim), 1'b0, 8'd0, 17'd0);
            return make(KIND_NONE, 4'd0, 1'b0, 8'd0, 17'd0);
         end
         if (ev.mode > MODE_IDLE || ev.cpu >= n)
            return make(KIND_NONE, 4'd0, 1'b0, 8'd0, 17'd0);
         case (ev.mode)
            MODE_PREEMPT: begin
               if (run_busy[ev.cpu]) begin
                  e = run_tab[ev.cpu];
                  run_busy[ev.cpu] = 0;
                  if (ready_cnt >= 16)
                     return make(KIND_OVERFLOW, ev.cpu, 1'b0, 8'd0, 17'd0);
                  e.remaining = ev.remaining;
                  e.enq = ev.now;
                  ready_tab[ready_cnt] = e;
                  ready_cnt++;
               end
            end
            MODE_YIELD, MODE_TERM: run_busy[ev.cpu] = 0;
            default: begin
               if (run_busy[ev.cpu] || ready_cnt == 0)
                  return make(KIND_NONE, 4'd0, 1'b0, 8'd0, 17'd0);
            end
         endcase
         return dispatch(ev.cpu, ev.now);
      endfunction

      function void note_event(sched_event_type ev);
         expected_q.push_back(predict(ev));
      endfunction

      function void check_result(sched_result_type got);
         sched_result_type exp_r;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result kind=%0d cpu=%0d", $time, got.kind, got.cpu);
            errors++;
            return;
         end
         exp_r = expected_q.pop_front();
         case (exp_r.kind)
            KIND_DISPATCH: n_dispatch++;
            KIND_PREEMPT:  n_preempt++;
            KIND_OVERFLOW: n_overflow++;
            default:       n_none++;
         endcase
         if (got.kind !== exp_r.kind || got.cpu !== exp_r.cpu || got.present !== exp_r.present
             || got.tid !== exp_r.tid || got.slice !== exp_r.slice) begin
            $display("%0t: mismatch expected kind=%0d cpu=%0d present=%0d task=%0d slice=%h",
                     $time, exp_r.kind, exp_r.cpu, exp_r.present, exp_r.tid, exp_r.slice);
            $display("%0t:          actual   kind=%0d cpu=%0d present=%0d task=%0d slice=%h",
                     $time, got.kind, got.cpu, got.present, got.tid, got.slice);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [16:0] csr_wdata;
   bit          quiet;
   int          idle_cycles;
   int          items_sent;
   logic [15:0] now_t;

   mpcs_req_if req_chan ();
   mpcs_rsp_if rsp_chan ();

   sched_scoreboard sb;

   multi_policy_cpu_scheduler_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // gap length: mostly short, sometimes long
   function int pick_gap();
      if (quiet || $urandom_range(0, 2) != 0) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
      return $urandom_range(1, 3);
   endfunction

   // result side back-pressure
   int stall_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 0;
      end else begin
         rsp_chan.ready <= 1;
         stall_left = pick_gap();
      end
   end

   // accepted items and results
   always @(posedge clock) begin
      sched_event_type  ev;
      sched_result_type r;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            ev.mode = req_chan.mode; ev.cpu = req_chan.cpu_index; ev.tid = req_chan.task_id;
            ev.prio = req_chan.prio_level; ev.arrival = req_chan.arrival_stamp;
            ev.remaining = req_chan.remaining_time; ev.now = req_chan.now_stamp;
            sb.note_event(ev);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            r.kind = kind_type'(rsp_chan.result_kind); r.cpu = rsp_chan.cpu_out;
            r.present = rsp_chan.task_present; r.tid = rsp_chan.task_out;
            r.slice = rsp_chan.slice_out;
            sb.check_result(r);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_event(logic [2:0] mode, logic [3:0] cpu, logic [7:0] tid,
                             logic [7:0] prio, logic [15:0] arr, logic [15:0] rem,
                             logic [15:0] now);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1;
      req_chan.mode <= mode;
      req_chan.cpu_index <= cpu;
      req_chan.task_id <= tid;
      req_chan.prio_level <= prio;
      req_chan.arrival_stamp <= arr;
      req_chan.remaining_time <= rem;
      req_chan.now_stamp <= now;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
   endtask

   // stop sending and let every expected result come back
   task automatic drain();
      req_chan.valid <= 0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [16:0] d);
      @(posedge clock);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= d;
      sb.set_reg(idx, d);
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   task automatic configure(policy_type p, logic [7:0] w, logic [16:0] s, logic [4:0] c);
      write_reg(CSR_POLICY, {15'd0, p});
      write_reg(CSR_WEIGHT, {9'd0, w});
      write_reg(CSR_SLICE, s);
      write_reg(CSR_CPUS, {12'd0, c});
   endtask

   // one random event of a scheduling workload, with some noise
   task automatic random_event(int ncpu);
      int          r;
      logic [2:0]  mode;
      logic [3:0]  cpu;
      logic [15:0] arr;
      logic [15:0] rem;
      r = $urandom_range(0, 99);
      now_t = ($urandom_range(0, 19) == 0) ? 16'($urandom)
                                           : 16'(now_t + $urandom_range(0, 50));
      cpu = 4'($urandom_range(0, ncpu - 1));
      if (r < 35) mode = MODE_WAKE;
      else if (r < 55) mode = MODE_IDLE;
      else if (r < 68) mode = MODE_PREEMPT;
      else if (r < 78) mode = MODE_YIELD;
      else if (r < 88) mode = MODE_TERM;
      else if (r < 94) begin
         mode = 3'($urandom_range(1, 4));
         cpu = 4'($urandom_range(0, 15));
      end else
         mode = 3'($urandom_range(5, 7));
      arr = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                        : 16'(now_t - $urandom_range(0, 200));
      rem = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
      send_event(mode, cpu, 8'($urandom), 8'($urandom), arr, rem, now_t);
   endtask

   initial begin
      int          ncpu;
      logic [7:0]  w;
      logic [16:0] s;
      sb = new();
      sb.clear();
      items_sent = 0;
      idle_cycles = 0;
      now_t = 0;
      quiet = 0;
      reset <= 1;
      csr_wr_en <= 0;
      csr_index <= CSR_POLICY;
      csr_wdata <= 0;
      req_chan.valid <= 0;
      req_chan.mode <= MODE_WAKE;
      req_chan.cpu_index <= 0;
      req_chan.task_id <= 0;
      req_chan.prio_level <= 0;
      req_chan.arrival_stamp <= 0;
      req_chan.remaining_time <= 0;
      req_chan.now_stamp <= 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: two CPUs under SRTF
      configure(POL_SRTF, 8'd0, 17'd100, 5'd2);
      send_event(MODE_IDLE, 0, 0, 0, 0, 0, 0);               // empty table
      send_event(MODE_WAKE, 0, 255, 255, 16'hFFFF, 16'hFFFF, 0);
      send_event(MODE_WAKE, 0, 1, 0, 3, 10, 5);
      send_event(MODE_IDLE, 0, 0, 0, 0, 0, 6);
      send_event(MODE_IDLE, 1, 0, 0, 0, 0, 7);
      send_event(MODE_WAKE, 0, 2, 4, 8, 5, 8);               // asks to preempt
      send_event(MODE_PREEMPT, 1, 0, 0, 0, 40000, 9);
      send_event(MODE_YIELD, 0, 0, 0, 0, 0, 10);
      send_event(MODE_TERM, 1, 0, 0, 0, 0, 11);
      send_event(MODE_IDLE, 0, 0, 0, 0, 0, 12);              // CPU busy
      send_event(MODE_PREEMPT, 15, 0, 0, 0, 0, 13);          // CPU out of range
      send_event(3'd7, 0, 0, 0, 0, 0, 14);                   // unknown mode
      for (int i = 0; i < 17; i++)                           // last one overflows
         send_event(MODE_WAKE, 0, 8'(i + 16), 8'(i), 16'(i), 16'(100 + i), 16'hFFFF);
      send_event(MODE_PREEMPT, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF); // full table
      send_event(MODE_IDLE, 0, 0, 0, 0, 0, 0);
      drain();

      // random phases across policy, weight, slice and CPU count settings
      for (int ph = 0; ph < PHASES; ph++) begin
         quiet = (ph % 3 == 2);
         case (ph % 5)
            0: w = 0;
            1: w = 8'hFF;
            default: w = 8'($urandom);
         endcase
         case (ph % 4)
            0: s = SLICE_NONE;
            1: s = 0;
            2: s = 17'd65535;
            default: s = 17'($urandom_range(0, 65535));
         endcase
         case ((ph / 2) % 3)
            0: ncpu = 1;
            1: ncpu = 16;
            default: ncpu = $urandom_range(1, 16);
         endcase
         configure(policy_type'(ph % 4), w, s, 5'(ncpu));
         for (int k = 0; k < PHASE_LEN; k++) begin
            random_event(ncpu);
            if (k == PHASE_LEN / 2 && ph % 4 == 1) drain();
         end
         drain();
      end

      $display("%0d items over %0d setting phases: %0d dispatches, %0d preempt requests,",
               items_sent, PHASES + 1, sb.n_dispatch, sb.n_preempt);
      $display("%0d overflows, %0d no-action results, %0d errors",
               sb.n_overflow, sb.n_none, sb.errors);
      if (sb.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* filelist.f */
rtl/mpcs_pkg.sv
rtl/mpcs_if.sv
rtl/mpcs_ready_cell.sv
rtl/multi_policy_cpu_scheduler_core.sv
test/tb_multi_policy_cpu_scheduler_core.sv
